>>> src/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg: shared types and constants of the data set median block
// Holds the fixed output widths and the controller state type.
// ----------------------------------------------------------------------------
package dsm_pkg;

    // Fixed widths of the result word.
    localparam int MEDIAN_W = 32;
    localparam int COUNT_W  = 7;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PICK,
        ST_AVG
    } t_state;

endpackage

>>> src/dsm_ifs.sv
// ----------------------------------------------------------------------------
// dsm_ifs: handshake channels of the data set median block
// Sample channel in, result channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface dsm_smp_if #(
    parameter int SAMPLE_WIDTH = 32
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic                    last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface dsm_med_if;
    logic                             valid;
    logic                             ready;
    logic [dsm_pkg::MEDIAN_W-1:0]     median;
    logic [dsm_pkg::COUNT_W-1:0]      count_used;
    logic                             overflow;

    modport source (output valid, output median, output count_used, output overflow,
                    input ready);
    modport sink   (input valid, input median, input count_used, input overflow,
                    output ready);
endinterface

>>> src/dsm_cell.sv
// ----------------------------------------------------------------------------
// dsm_cell: one cell of the sorted insertion chain
// Holds one stored sample, compares it with the incoming sample and takes
// either its left neighbor's value or the new sample when an insert moves it.
// ----------------------------------------------------------------------------
module dsm_cell #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int CW           = 7,
    parameter int INDEX        = 0
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [CW-1:0]           i_count,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic                    i_left_gt,
    input  logic [SAMPLE_WIDTH-1:0] i_left_val,
    input  logic [CW-1:0]           i_mid_lo,
    input  logic [CW-1:0]           i_mid_hi,
    output logic                    o_gt,
    output logic [SAMPLE_WIDTH-1:0] o_val,
    output logic [SAMPLE_WIDTH-1:0] o_pick_lo,
    output logic [SAMPLE_WIDTH-1:0] o_pick_hi
);

    logic [SAMPLE_WIDTH-1:0] r_val;
    logic                    occupied;
    logic                    at_end;

    assign occupied = CW'(INDEX) < i_count;
    assign at_end   = CW'(INDEX) == i_count;

    // The chain is sorted, so the greater-than flags rise monotonically along its occupied cells.
    assign o_gt  = occupied && ($signed(r_val) > $signed(i_sample));
    assign o_val = r_val;

    assign o_pick_lo = (CW'(INDEX) == i_mid_lo) ? r_val : '0;
    assign o_pick_hi = (CW'(INDEX) == i_mid_hi) ? r_val : '0;

    always_ff @(posedge i_clk) begin
        if (i_load && (o_gt || at_end)) begin
            r_val <= i_left_gt ? i_left_val : i_sample;
        end
    end

endmodule

>>> src/dsm_avg.sv
// ----------------------------------------------------------------------------
// dsm_avg: median arithmetic and result register
// Forms the middle element or the floored average of the two middle elements
// and holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
module dsm_avg #(
    parameter int SAMPLE_WIDTH = 32,
    parameter int CW           = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_go,
    input  logic [SAMPLE_WIDTH-1:0] i_lo,
    input  logic [SAMPLE_WIDTH-1:0] i_hi,
    input  logic [CW-1:0]           i_count,
    input  logic                    i_ovf,
    output logic                    o_free,
    dsm_med_if.source               o_med
);

    logic [SAMPLE_WIDTH:0]   sum;
    logic [SAMPLE_WIDTH-1:0] med;
    logic                    r_valid;
    logic [dsm_pkg::MEDIAN_W-1:0] r_median;
    logic [dsm_pkg::COUNT_W-1:0]  r_count;
    logic                    r_ovf;

    // Sign-extended sum one bit wider; dropping its low bit is a flooring shift.
    assign sum = {i_lo[SAMPLE_WIDTH-1], i_lo} + {i_hi[SAMPLE_WIDTH-1], i_hi};
    assign med = i_count[0] ? i_hi : sum[SAMPLE_WIDTH:1];

    assign o_free = !r_valid || o_med.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_go) begin
            r_valid <= 1'b1;
        end else if (o_med.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_median <= dsm_pkg::MEDIAN_W'(med);
            r_count  <= dsm_pkg::COUNT_W'(i_count);
            r_ovf    <= i_ovf;
        end
    end

    assign o_med.valid      = r_valid;
    assign o_med.median     = r_median;
    assign o_med.count_used = r_count;
    assign o_med.overflow   = r_ovf;

endmodule

>>> src/data_set_median.sv
// ----------------------------------------------------------------------------
// data_set_median: median of a data set by a systolic insertion chain
// Samples are inserted into a row of sorted cells; the word marked last
// closes the set and yields its median.
// ----------------------------------------------------------------------------
//  channel  | dir | fields                          | handshake
//  i_smp    | in  | sample, last                    | valid/ready
//  o_med    | out | median, count_used, overflow    | valid/ready
//
// One sample word is taken per cycle while ready is high in the loading state;
// every cell compares and shifts at once. After the word marked last, ready is
// low in the pick and averaging steps, as the chain picks the middle cells and
// the adder forms the median; the block waits in the averaging step while the
// result register is occupied. Reset clears the fill count, the overflow flag,
// the controller and the result valid; cell contents are not cleared.
// ----------------------------------------------------------------------------
module data_set_median #(
    parameter int MAX_SAMPLES  = 64,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dsm_smp_if.sink   i_smp,
    dsm_med_if.source o_med
);

    localparam int CW = $clog2(MAX_SAMPLES + 1);

    dsm_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_fill;
    logic            r_dropped;
    logic [CW-1:0]   r_set_count;
    logic            r_set_ovf;
    logic [SAMPLE_WIDTH-1:0] r_lo, r_hi;

    logic            accept;
    logic            full;
    logic            load;
    logic            go;
    logic            free;
    logic [CW-1:0]   mid_hi, mid_lo;
    logic [SAMPLE_WIDTH-1:0] pick_lo, pick_hi;

    logic [MAX_SAMPLES-1:0]  gt;
    logic [SAMPLE_WIDTH-1:0] val     [MAX_SAMPLES];
    logic [SAMPLE_WIDTH-1:0] cell_lo [MAX_SAMPLES];
    logic [SAMPLE_WIDTH-1:0] cell_hi [MAX_SAMPLES];

    assign i_smp.ready = (r_state == dsm_pkg::ST_LOAD);
    assign accept      = i_smp.valid && i_smp.ready;
    assign full        = (r_fill == CW'(MAX_SAMPLES));
    assign load        = accept && !full;

    assign mid_hi = r_set_count >> 1;
    assign mid_lo = mid_hi - CW'(1);

    genvar k;
    generate
        for (k = 0; k < MAX_SAMPLES; k++) begin : g_cell
            logic                    left_gt;
            logic [SAMPLE_WIDTH-1:0] left_val;
            if (k == 0) begin : g_first
                assign left_gt  = 1'b0;
                assign left_val = i_smp.sample;
            end else begin : g_rest
                assign left_gt  = gt[k-1];
                assign left_val = val[k-1];
            end
            dsm_cell #(
                .SAMPLE_WIDTH(SAMPLE_WIDTH),
                .CW(CW),
                .INDEX(k)
            ) u_cell (
                .i_clk      (i_clk),
                .i_load     (load),
                .i_count    (r_fill),
                .i_sample   (i_smp.sample),
                .i_left_gt  (left_gt),
                .i_left_val (left_val),
                .i_mid_lo   (mid_lo),
                .i_mid_hi   (mid_hi),
                .o_gt       (gt[k]),
                .o_val      (val[k]),
                .o_pick_lo  (cell_lo[k]),
                .o_pick_hi  (cell_hi[k])
            );
        end
    endgenerate

    // Only the middle cells drive a nonzero pick, so an OR gathers them.
    always_comb begin
        pick_lo = '0;
        pick_hi = '0;
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            pick_lo = pick_lo | cell_lo[i];
            pick_hi = pick_hi | cell_hi[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dsm_pkg::ST_LOAD;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if (i_smp.last) begin
                    r_fill    <= '0;
                    r_dropped <= 1'b0;
                end else if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_smp.last) begin
            r_set_count <= full ? r_fill : r_fill + CW'(1);
            r_set_ovf   <= r_dropped || full;
        end
        if (r_state == dsm_pkg::ST_PICK) begin
            r_lo <= pick_lo;
            r_hi <= pick_hi;
        end
    end

    always_comb begin
        n_state = r_state;
        go      = 1'b0;
        case (r_state)
            dsm_pkg::ST_LOAD: begin
                if (accept && i_smp.last) begin
                    n_state = dsm_pkg::ST_PICK;
                end
            end
            dsm_pkg::ST_PICK: begin
                n_state = dsm_pkg::ST_AVG;
            end
            dsm_pkg::ST_AVG: begin
                if (free) begin
                    go      = 1'b1;
                    n_state = dsm_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = dsm_pkg::ST_LOAD;
            end
        endcase
    end

    dsm_avg #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .CW(CW)
    ) u_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_lo    (r_lo),
        .i_hi    (r_hi),
        .i_count (r_set_count),
        .i_ovf   (r_set_ovf),
        .o_free  (free),
        .o_med   (o_med)
    );

endmodule
